// ===== rtl/core/prrs_pkg.sv =====
`default_nettype none

package prrs_pkg;

  // Fixed field widths of the command and result words
  localparam int CMD_W  = 3;
  localparam int ID_W   = 5;
  localparam int PRIO_W = 3;

  localparam int TASK_SLOTS_DEF     = 32;
  localparam int PRIORITY_COUNT_DEF = 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_PICK   = 3'd0,
    CMD_ADD    = 3'd1,
    CMD_EXIT   = 3'd2,
    CMD_INSERT = 3'd3,
    CMD_REMOVE = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    OP_NONE   = 2'd0,
    OP_PICK   = 2'd1,
    OP_LINK   = 2'd2,
    OP_UNLINK = 2'd3
  } op_kind_t;

  // Decoded operation handed from the front end to the executor
  typedef struct packed {
    op_kind_t            kind;
    logic                count_up;
    logic                count_down;
    logic [ID_W-1:0]     task_id;
    logic [PRIO_W-1:0]   level;
  } op_t;

endpackage

`default_nettype wire

// ===== rtl/core/prrs_in_if.sv =====
`default_nettype none

interface prrs_in_if import prrs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [ID_W-1:0]   task_id;
  logic [PRIO_W-1:0] task_priority;

  modport source (output valid, command, task_id, task_priority, input ready);
  modport sink   (input valid, command, task_id, task_priority, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/prrs_out_if.sv =====
`default_nettype none

interface prrs_out_if import prrs_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [ID_W-1:0] chosen_task;
  logic            chosen_idle;
  logic            status;

  modport source (output valid, chosen_task, chosen_idle, status, input ready);
  modport sink   (input valid, chosen_task, chosen_idle, status, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/prrs_ram.sv =====
`default_nettype none

module prrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/prrs_front.sv =====
`default_nettype none

module prrs_front import prrs_pkg::*; #(
  parameter int TASK_SLOTS     = TASK_SLOTS_DEF,
  parameter int PRIORITY_COUNT = PRIORITY_COUNT_DEF
) (
  prrs_in_if.sink   request,
  input  wire logic push_ready,
  output      logic push,
  output      op_t  push_op
);

  logic [PRIO_W-1:0] level;
  logic              id_ok;

  assign request.ready = push_ready;
  assign push          = request.valid && push_ready;

  // Clamp the level into 1 .. PRIORITY_COUNT-1
  always_comb begin
    level = request.task_priority;
    if (level == '0) begin
      level = PRIO_W'(1);
    end else if (int'(level) >= PRIORITY_COUNT) begin
      level = PRIO_W'(PRIORITY_COUNT - 1);
    end
  end

  assign id_ok = int'(request.task_id) < TASK_SLOTS;

  always_comb begin
    push_op.kind       = OP_NONE;
    push_op.count_up   = 1'b0;
    push_op.count_down = 1'b0;
    push_op.task_id    = request.task_id;
    push_op.level      = level;
    unique case (cmd_t'(request.command))
      CMD_PICK: begin
        push_op.kind = OP_PICK;
      end
      CMD_ADD: begin
        push_op.kind     = id_ok ? OP_LINK : OP_NONE;
        push_op.count_up = id_ok;
      end
      CMD_EXIT: begin
        push_op.kind       = id_ok ? OP_UNLINK : OP_NONE;
        push_op.count_down = id_ok;
      end
      CMD_INSERT: begin
        push_op.kind = id_ok ? OP_LINK : OP_NONE;
      end
      CMD_REMOVE: begin
        push_op.kind = id_ok ? OP_UNLINK : OP_NONE;
      end
      default: begin
        push_op.kind = OP_NONE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/prrs_queue.sv =====
`default_nettype none

module prrs_queue import prrs_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire op_t  push_op,
  output      logic push_ready,
  input  wire logic pop,
  output      logic pop_valid,
  output      op_t  pop_op
);

  // Two-entry queue between decode and execution
  op_t        entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign push_ready = fill != 2'd2;
  assign pop_valid  = fill != 2'd0;
  assign pop_op     = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/prrs_back.sv =====
`default_nettype none

module prrs_back import prrs_pkg::*; #(
  parameter int TASK_SLOTS     = TASK_SLOTS_DEF,
  parameter int PRIORITY_COUNT = PRIORITY_COUNT_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   q_valid,
  input  wire op_t    q_op,
  output      logic   q_pop,
  prrs_out_if.source  response
);

  localparam int SLOT_W  = $clog2(TASK_SLOTS);
  localparam int LEVEL_W = $clog2(PRIORITY_COUNT);
  localparam int CNT_W   = $clog2(TASK_SLOTS + 1);

  typedef enum logic [3:0] {
    S_IDLE    = 4'b0001,
    S_PICK    = 4'b0010,
    S_LINK_W1 = 4'b0100,
    S_UNLINK  = 4'b1000
  } state_t;

  // Linking into a non-empty ring writes its links in a first and a second phase
  typedef enum logic [1:0] {
    LP_FIRST  = 2'b01,
    LP_SECOND = 2'b10
  } link_phase_t;

  state_t      state, state_next;
  link_phase_t phase, phase_next;

  logic [PRIORITY_COUNT-1:0] nonempty;
  logic [SLOT_W-1:0]         ring_current [PRIORITY_COUNT];
  logic [CNT_W-1:0]          count;

  logic [SLOT_W-1:0]  t_q;
  logic [SLOT_W-1:0]  before_q;
  logic [LEVEL_W-1:0] lvl_q;
  logic               up_q;
  logic               dn_q;

  logic [ID_W+SLOT_W-1:0]    slot_wide;
  logic [SLOT_W-1:0]         slot;
  logic [PRIO_W+LEVEL_W-1:0] lvl_wide;
  logic [LEVEL_W-1:0]        op_lvl;

  logic               pick_found;
  logic [LEVEL_W-1:0] pick_lvl;
  logic [LEVEL_W-1:0] rc_ra;
  logic [SLOT_W-1:0]  cur_rd;
  logic               full;
  logic               fin_ok;
  logic               commit;
  logic               latch;

  logic [SLOT_W-1:0]  nx_rd, pv_rd;
  logic [LEVEL_W-1:0] pr_rd;
  logic               rd_en;
  logic [SLOT_W-1:0]  nx_ra;
  logic               nx_we, pv_we, pr_we;
  logic [SLOT_W-1:0]  nx_wa, nx_wd, pv_wa, pv_wd;

  logic               rc_we;
  logic [LEVEL_W-1:0] rc_wa;
  logic [SLOT_W-1:0]  rc_wd;
  logic               ne_set, ne_clr;
  logic [LEVEL_W-1:0] ne_lvl;
  logic               cnt_up, cnt_dn;

  logic [SLOT_W-1:0]        res_chosen;
  logic                     res_idle, res_status;
  logic [SLOT_W+ID_W-1:0]   chosen_wide;

  logic               out_valid;

  assign slot_wide = {{SLOT_W{1'b0}}, q_op.task_id};
  assign slot      = slot_wide[SLOT_W-1:0];
  assign lvl_wide  = {{LEVEL_W{1'b0}}, q_op.level};
  assign op_lvl    = lvl_wide[LEVEL_W-1:0];

  // Highest non-empty level; level zero never holds a task
  always_comb begin
    pick_found = 1'b0;
    pick_lvl   = '0;
    for (int i = 1; i < PRIORITY_COUNT; i++) begin
      if (nonempty[i]) begin
        pick_found = 1'b1;
        pick_lvl   = LEVEL_W'(i);
      end
    end
  end

  assign rc_ra  = (q_op.kind == OP_PICK) ? pick_lvl : op_lvl;
  assign cur_rd = ring_current[rc_ra];
  assign full   = int'(count) >= TASK_SLOTS;
  assign fin_ok = !out_valid || response.ready;

  prrs_ram #(.WIDTH(SLOT_W), .DEPTH(TASK_SLOTS)) u_next (
    .clk, .we(nx_we), .waddr(nx_wa), .wdata(nx_wd),
    .re(rd_en), .raddr(nx_ra), .rdata(nx_rd)
  );

  prrs_ram #(.WIDTH(SLOT_W), .DEPTH(TASK_SLOTS)) u_prev (
    .clk, .we(pv_we), .waddr(pv_wa), .wdata(pv_wd),
    .re(rd_en), .raddr(slot), .rdata(pv_rd)
  );

  prrs_ram #(.WIDTH(LEVEL_W), .DEPTH(TASK_SLOTS)) u_prio (
    .clk, .we(pr_we), .waddr(slot), .wdata(op_lvl),
    .re(rd_en), .raddr(slot), .rdata(pr_rd)
  );

  always_comb begin
    state_next = state;
    phase_next = phase;
    q_pop      = 1'b0;
    commit     = 1'b0;
    latch      = 1'b0;
    res_chosen = '0;
    res_idle   = 1'b0;
    res_status = 1'b0;
    rd_en      = 1'b0;
    nx_ra      = slot;
    nx_we      = 1'b0;
    nx_wa      = slot;
    nx_wd      = slot;
    pv_we      = 1'b0;
    pv_wa      = slot;
    pv_wd      = slot;
    pr_we      = 1'b0;
    rc_we      = 1'b0;
    rc_wa      = op_lvl;
    rc_wd      = slot;
    ne_set     = 1'b0;
    ne_clr     = 1'b0;
    ne_lvl     = op_lvl;
    cnt_up     = 1'b0;
    cnt_dn     = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (q_valid) begin
          unique case (q_op.kind)
            OP_PICK: begin
              if (pick_found) begin
                q_pop      = 1'b1;
                rd_en      = 1'b1;
                nx_ra      = cur_rd;
                latch      = 1'b1;
                state_next = S_PICK;
              end else if (fin_ok) begin
                q_pop    = 1'b1;
                commit   = 1'b1;
                res_idle = 1'b1;
              end
            end
            OP_LINK: begin
              if (q_op.count_up && full) begin
                if (fin_ok) begin
                  q_pop      = 1'b1;
                  commit     = 1'b1;
                  res_status = 1'b1;
                end
              end else if (!nonempty[op_lvl]) begin
                // first task of its level points at itself
                if (fin_ok) begin
                  q_pop  = 1'b1;
                  commit = 1'b1;
                  pr_we  = 1'b1;
                  nx_we  = 1'b1;
                  pv_we  = 1'b1;
                  rc_we  = 1'b1;
                  ne_set = 1'b1;
                  cnt_up = q_op.count_up;
                end
              end else begin
                q_pop      = 1'b1;
                pr_we      = 1'b1;
                rd_en      = 1'b1;
                nx_ra      = cur_rd;
                latch      = 1'b1;
                phase_next = LP_FIRST;
                state_next = S_LINK_W1;
              end
            end
            OP_UNLINK: begin
              q_pop      = 1'b1;
              rd_en      = 1'b1;
              latch      = 1'b1;
              state_next = S_UNLINK;
            end
            default: begin
              if (fin_ok) begin
                q_pop  = 1'b1;
                commit = 1'b1;
              end
            end
          endcase
        end
      end
      S_PICK: begin
        if (fin_ok) begin
          commit     = 1'b1;
          res_chosen = nx_rd;
          rc_we      = 1'b1;
          rc_wa      = lvl_q;
          rc_wd      = nx_rd;
          state_next = S_IDLE;
        end
      end
      S_LINK_W1: begin
        // nx_rd holds the successor of the current slot throughout
        unique case (phase)
          LP_FIRST: begin
            nx_we      = 1'b1;
            nx_wa      = t_q;
            nx_wd      = nx_rd;
            pv_we      = 1'b1;
            pv_wa      = t_q;
            pv_wd      = before_q;
            phase_next = LP_SECOND;
          end
          LP_SECOND: begin
            if (fin_ok) begin
              commit     = 1'b1;
              nx_we      = 1'b1;
              nx_wa      = before_q;
              nx_wd      = t_q;
              pv_we      = 1'b1;
              pv_wa      = nx_rd;
              pv_wd      = t_q;
              cnt_up     = up_q;
              state_next = S_IDLE;
            end
          end
          default: begin
            phase_next = LP_FIRST;
          end
        endcase
      end
      S_UNLINK: begin
        if (fin_ok) begin
          commit = 1'b1;
          cnt_dn = dn_q;
          ne_lvl = pr_rd;
          rc_we  = 1'b1;
          rc_wa  = pr_rd;
          if (nx_rd == t_q) begin
            ne_clr = 1'b1;
            rc_wd  = '0;
          end else begin
            nx_we = 1'b1;
            nx_wa = pv_rd;
            nx_wd = nx_rd;
            pv_we = 1'b1;
            pv_wa = nx_rd;
            pv_wd = pv_rd;
            rc_wd = pv_rd;
          end
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      phase    <= LP_FIRST;
      nonempty <= '0;
      count    <= '0;
    end else begin
      state <= state_next;
      phase <= phase_next;
      if (ne_set) begin
        nonempty[ne_lvl] <= 1'b1;
      end else if (ne_clr) begin
        nonempty[ne_lvl] <= 1'b0;
      end
      if (cnt_up) begin
        count <= count + CNT_W'(1);
      end else if (cnt_dn && count != '0) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rc_we) begin
      ring_current[rc_wa] <= rc_wd;
    end
    if (latch) begin
      t_q      <= slot;
      before_q <= cur_rd;
      lvl_q    <= pick_lvl;
      up_q     <= q_op.count_up;
      dn_q     <= q_op.count_down;
    end
  end

  // Result register: a new word loads only when the slot is free
  assign chosen_wide = {{ID_W{1'b0}}, res_chosen};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (response.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      response.chosen_task <= chosen_wide[ID_W-1:0];
      response.chosen_idle <= res_idle;
      response.status      <= res_status;
    end
  end

  assign response.valid = out_valid;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    int'(count) <= TASK_SLOTS)
    else $error("registered task count above table size");

  a_level0_unused: assert property (@(posedge clk) disable iff (rst)
    !nonempty[0])
    else $error("level zero ring marked non-empty");

  a_pop_when_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> state == S_IDLE)
    else $error("queue popped while an operation is in flight");

  a_idle_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && response.chosen_idle |-> response.chosen_task == '0 && !response.status)
    else $error("idle pick carries a task or status");

endmodule

`default_nettype wire

// ===== rtl/core/priority_round_robin_scheduler.sv =====
// Fixed-priority round-robin task scheduler.
// request channel: one command word (pick, add, exit, insert, remove) with
// task_id and task_priority. response channel: exactly one word per command,
// carrying chosen_task and chosen_idle for a pick and status for an add.
// A decoder accepts and classifies commands into a two-entry queue; an
// executor works them off against the link memories (next, prev, level),
// each a single-port-write RAM with registered read, and fills one output
// register.
// Executor steps per command: an idle pick, a refused add, a slot out of
// range, an unknown command and linking the first task of a level finish
// in S_IDLE. Every other command first issues the registered reads of the
// link RAMs; a pick then finishes in S_PICK, an exit or remove in S_UNLINK
// and linking into a non-empty ring in S_LINK_W1 (LP_FIRST, LP_SECOND),
// with the read-modify-write of neighbor links, one write per RAM per cycle.
// The executor takes a new command only after finishing the last one.
// Reset clears the ring-occupied flags, task count, queue and output
// valid flag; link memories need no clearing. When the receiver stalls, the
// finished word holds, the executor waits on its last step and the queue
// keeps taking commands until it holds two.
`default_nettype none

module priority_round_robin_scheduler import prrs_pkg::*; #(
  parameter int TASK_SLOTS     = TASK_SLOTS_DEF,
  parameter int PRIORITY_COUNT = PRIORITY_COUNT_DEF
) (
  input wire logic   clk,
  input wire logic   rst,
  prrs_in_if.sink    request,
  prrs_out_if.source response
);

  logic push, push_ready;
  op_t  push_op;
  logic pop, pop_valid;
  op_t  pop_op;

  prrs_front #(
    .TASK_SLOTS(TASK_SLOTS),
    .PRIORITY_COUNT(PRIORITY_COUNT)
  ) u_front (
    .request,
    .push_ready,
    .push,
    .push_op
  );

  prrs_queue u_queue (
    .clk,
    .rst,
    .push,
    .push_op,
    .push_ready,
    .pop,
    .pop_valid,
    .pop_op
  );

  prrs_back #(
    .TASK_SLOTS(TASK_SLOTS),
    .PRIORITY_COUNT(PRIORITY_COUNT)
  ) u_back (
    .clk,
    .rst,
    .q_valid(pop_valid),
    .q_op(pop_op),
    .q_pop(pop),
    .response
  );

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`default_nettype none

module tb_top;
  import prrs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_SLOTS    = TASK_SLOTS_DEF;
  localparam int NUM_LEVELS   = PRIORITY_COUNT_DEF;
  localparam int STALL_LIMIT  = 5000;
  localparam int LONG_HOLD    = 400;
  localparam int DRAIN_CYCLES = 10;
  localparam int PHASE_ITEMS  = 508;
  localparam int SEGMENT_LEN  = 80;
  localparam int NOISE_START  = 360;

  localparam logic [CMD_W-1:0] CMD_SPARE_LO  = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_MID = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI  = 3'd7;

  typedef struct packed {
    logic [ID_W-1:0] chosen_task;
    logic            chosen_idle;
    logic            status;
  } sched_word_t;

  typedef struct {
    logic [CMD_W-1:0]  cmd;
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
    bit                typed;
    sched_word_t       want;
  } script_row_t;

  typedef enum int {MIX_DRAIN, MIX_FILL, MIX_CHURN} mix_t;

  localparam sched_word_t WORD_NONE = '0;
  localparam sched_word_t WORD_IDLE = '{chosen_task: '0, chosen_idle: 1'b1, status: 1'b0};

  localparam int SCRIPT_LEN = 25;

  script_row_t script [SCRIPT_LEN] = '{
    '{CMD_PICK,      5'd0,  3'd0, 1'b1, WORD_IDLE},
    '{CMD_INSERT,    5'd3,  3'd0, 1'b1, WORD_NONE},
    '{CMD_PICK,      5'd31, 3'd7, 1'b1, '{5'd3, 1'b0, 1'b0}},
    '{CMD_EXIT,      5'd3,  3'd7, 1'b1, WORD_NONE},
    '{CMD_PICK,      5'd0,  3'd0, 1'b1, WORD_IDLE},
    '{CMD_ADD,       5'd31, 3'd7, 1'b1, WORD_NONE},
    '{CMD_ADD,       5'd0,  3'd7, 1'b1, WORD_NONE},
    '{CMD_PICK,      5'd0,  3'd0, 1'b0, WORD_NONE},
    '{CMD_PICK,      5'd31, 3'd7, 1'b0, WORD_NONE},
    '{CMD_ADD,       5'd17, 3'd1, 1'b1, WORD_NONE},
    '{CMD_INSERT,    5'd21, 3'd6, 1'b1, WORD_NONE},
    '{CMD_PICK,      5'd0,  3'd0, 1'b0, WORD_NONE},
    '{CMD_REMOVE,    5'd31, 3'd0, 1'b0, WORD_NONE},
    '{CMD_PICK,      5'd0,  3'd0, 1'b0, WORD_NONE},
    '{CMD_REMOVE,    5'd0,  3'd0, 1'b0, WORD_NONE},
    '{CMD_PICK,      5'd0,  3'd0, 1'b0, WORD_NONE},
    '{CMD_REMOVE,    5'd0,  3'd7, 1'b0, WORD_NONE},
    '{CMD_INSERT,    5'd21, 3'd6, 1'b0, WORD_NONE},
    '{CMD_PICK,      5'd0,  3'd0, 1'b0, WORD_NONE},
    '{CMD_SPARE_LO,  5'd31, 3'd7, 1'b1, WORD_NONE},
    '{CMD_SPARE_MID, 5'd31, 3'd7, 1'b1, WORD_NONE},
    '{CMD_SPARE_HI,  5'd31, 3'd7, 1'b1, WORD_NONE},
    '{CMD_EXIT,      5'd21, 3'd0, 1'b0, WORD_NONE},
    '{CMD_EXIT,      5'd17, 3'd0, 1'b0, WORD_NONE},
    '{CMD_PICK,      5'd0,  3'd0, 1'b0, WORD_NONE}
  };

  logic clk = 1'b0;
  logic rst;

  prrs_in_if  req_if ();
  prrs_out_if rsp_if ();

  priority_round_robin_scheduler uut (
    .clk      (clk),
    .rst      (rst),
    .request  (req_if),
    .response (rsp_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // scheduler state as seen by the predictor
  logic [ID_W-1:0]   lvl_cursor [NUM_LEVELS];
  bit                lvl_live   [NUM_LEVELS];
  logic [ID_W-1:0]   fwd        [NUM_SLOTS];
  logic [ID_W-1:0]   bwd        [NUM_SLOTS];
  logic [PRIO_W-1:0] slot_lvl   [NUM_SLOTS];
  int                task_total;

  // generator bookkeeping: slots ever written, slots on a ring if all went well
  bit ever_linked [NUM_SLOTS];
  bit on_ring     [NUM_SLOTS];

  sched_word_t sched_due_q [$];

  int fails = 0;
  int quiet_cycles = 0;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_trigger;

  function automatic logic [PRIO_W-1:0] clamp_level(logic [PRIO_W-1:0] p);
    if (p == 0) return PRIO_W'(1);
    if (p >= NUM_LEVELS) return PRIO_W'(NUM_LEVELS - 1);
    return p;
  endfunction

  function automatic void link_slot(logic [ID_W-1:0] t, logic [PRIO_W-1:0] lv);
    logic [ID_W-1:0] b;
    logic [ID_W-1:0] a;
    slot_lvl[t] = lv;
    ever_linked[t] = 1'b1;
    if (!lvl_live[lv]) begin
      lvl_live[lv] = 1'b1;
      lvl_cursor[lv] = t;
      fwd[t] = t;
      bwd[t] = t;
    end else begin
      b = lvl_cursor[lv];
      a = fwd[b];
      bwd[t] = b;
      fwd[t] = a;
      fwd[b] = t;
      bwd[a] = t;
    end
  endfunction

  function automatic void unlink_slot(logic [ID_W-1:0] t);
    logic [PRIO_W-1:0] lv;
    logic [ID_W-1:0]   a;
    logic [ID_W-1:0]   b;
    lv = slot_lvl[t];
    a = fwd[t];
    b = bwd[t];
    if (a == t) begin
      lvl_live[lv] = 1'b0;
      lvl_cursor[lv] = '0;
    end else begin
      fwd[b] = a;
      bwd[a] = b;
      lvl_cursor[lv] = b;
    end
  endfunction

  function automatic sched_word_t schedule_step(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] id,
                                                logic [PRIO_W-1:0] prio);
    sched_word_t w;
    logic [ID_W-1:0] nx;
    w = WORD_NONE;
    case (cmd)
      CMD_PICK: begin
        w.chosen_idle = 1'b1;
        for (int lv = NUM_LEVELS - 1; lv >= 1; lv--) begin
          if (lvl_live[lv]) begin
            nx = fwd[lvl_cursor[lv]];
            lvl_cursor[lv] = nx;
            w.chosen_task = nx;
            w.chosen_idle = 1'b0;
            break;
          end
        end
      end
      CMD_ADD: begin
        if (task_total >= NUM_SLOTS) begin
          w.status = 1'b1;
        end else begin
          link_slot(id, clamp_level(prio));
          task_total++;
        end
      end
      CMD_EXIT: begin
        unlink_slot(id);
        if (task_total > 0) task_total--;
      end
      CMD_INSERT: link_slot(id, clamp_level(prio));
      CMD_REMOVE: unlink_slot(id);
      default: ;
    endcase
    return w;
  endfunction

  function automatic int find_slot(bit want_on, bit any_past);
    int cand [$];
    for (int s = 0; s < NUM_SLOTS; s++) begin
      if (any_past ? ever_linked[s] : (on_ring[s] == want_on)) cand.push_back(s);
    end
    if (cand.size() == 0) return -1;
    return cand[$urandom_range(0, cand.size() - 1)];
  endfunction

  // well-formed commands add only slots off their ring and remove only slots on it;
  // noisy exits and removes take any slot that was ever written, noisy adds any id
  function automatic void next_command(mix_t mix, bit noisy, output logic [CMD_W-1:0] cmd,
                                       output logic [ID_W-1:0] id,
                                       output logic [PRIO_W-1:0] prio);
    int   r;
    int   s;
    int   lim [5];
    cmd_t kind;
    case (mix)
      MIX_DRAIN: lim = '{35, 43, 73, 77, 97};
      MIX_FILL:  lim = '{25, 85, 92, 94, 98};
      default:   lim = '{35, 50, 62, 78, 94};
    endcase
    r = $urandom_range(0, 99);
    id = ID_W'($urandom);
    prio = PRIO_W'($urandom_range(0, 7));
    if (r >= lim[4]) begin
      cmd = CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
      return;
    end
    if (r < lim[0]) kind = CMD_PICK;
    else if (r < lim[1]) kind = CMD_ADD;
    else if (r < lim[2]) kind = CMD_EXIT;
    else if (r < lim[3]) kind = CMD_INSERT;
    else kind = CMD_REMOVE;
    case (kind)
      CMD_ADD, CMD_INSERT: begin
        if (!noisy && !(kind == CMD_ADD && task_total >= NUM_SLOTS)) begin
          s = find_slot(1'b0, 1'b0);
          if (s < 0) kind = CMD_PICK;
          else id = ID_W'(s);
        end
      end
      CMD_EXIT, CMD_REMOVE: begin
        s = noisy ? find_slot(1'b0, 1'b1) : find_slot(1'b1, 1'b0);
        if (s < 0) kind = CMD_PICK;
        else id = ID_W'(s);
      end
      default: ;
    endcase
    cmd = kind;
  endfunction

  task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id,
                           input logic [PRIO_W-1:0] prio, input bit typed,
                           input sched_word_t want);
    sched_word_t due;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid         <= 1'b1;
    req_if.command       <= cmd;
    req_if.task_id       <= id;
    req_if.task_priority <= prio;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    due = schedule_step(cmd, id, prio);
    sched_due_q.push_back(typed ? want : due);
    case (cmd)
      CMD_ADD:    if (!due.status) on_ring[id] = 1'b1;
      CMD_INSERT: on_ring[id] = 1'b1;
      CMD_EXIT, CMD_REMOVE: on_ring[id] = 1'b0;
      default: ;
    endcase
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_trigger != hold_seen) begin
        hold_seen = hold_trigger;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    sched_word_t want;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (sched_due_q.size() == 0) begin
        $error("unexpected word: chosen_task %0d chosen_idle %0b status %0b",
               rsp_if.chosen_task, rsp_if.chosen_idle, rsp_if.status);
        fails++;
      end else begin
        want = sched_due_q.pop_front();
        if (rsp_if.chosen_task !== want.chosen_task) begin
          $error("chosen_task: expected %0d, got %0d", want.chosen_task, rsp_if.chosen_task);
          fails++;
        end
        if (rsp_if.chosen_idle !== want.chosen_idle) begin
          $error("chosen_idle: expected %0b, got %0b", want.chosen_idle, rsp_if.chosen_idle);
          fails++;
        end
        if (rsp_if.status !== want.status) begin
          $error("status: expected %0b, got %0b", want.status, rsp_if.status);
          fails++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [CMD_W-1:0]  cmd;
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
    bit                noisy;
    hold_trigger = 0;
    task_total = 0;
    for (int l = 0; l < NUM_LEVELS; l++) begin
      lvl_live[l] = 1'b0;
      lvl_cursor[l] = '0;
    end
    for (int s = 0; s < NUM_SLOTS; s++) begin
      ever_linked[s] = 1'b0;
      on_ring[s] = 1'b0;
    end
    rst                  <= 1'b1;
    req_if.valid         <= 1'b0;
    req_if.command       <= CMD_PICK;
    req_if.task_id       <= '0;
    req_if.task_priority <= '0;
    send_idle_pct = 25;
    recv_idle_pct = 70;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      send_word(script[i].cmd, script[i].id, script[i].prio, script[i].typed, script[i].want);
    end

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin send_idle_pct = 25; recv_idle_pct = 70; end
        1: begin send_idle_pct = 70; recv_idle_pct = 25; end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          hold_trigger++;
        end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // broken sequences only near the end, once the clean rings have been exercised
        noisy = (ph == 2) && (n >= NOISE_START) && ($urandom_range(0, 99) < 30);
        next_command(mix_t'((n / SEGMENT_LEN) % 3), noisy, cmd, id, prio);
        send_word(cmd, id, prio, 1'b0, WORD_NONE);
      end
    end
    req_if.valid <= 1'b0;

    while (sched_due_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fails == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
